[hdl/lne_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lne_pkg;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_SP  = 8'd32;

    localparam logic [6:0] LIMIT_MIN   = 7'd2;
    localparam logic [6:0] LIMIT_MAX   = 7'd64;
    localparam logic [6:0] MAX_LEN_RST = 7'd64;

    localparam logic CFG_MAX_LENGTH  = 1'b0;
    localparam logic CFG_ECHO_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_EOL   = 2'd1,
        KIND_ERASE = 2'd2
    } t_kind;

    // one decoded input byte, expanded into beats by the burst stage
    typedef struct packed {
        t_kind      kind;
        logic       echo;
        logic [7:0] ch;
        logic [5:0] index;
        logic       done;
        logic [5:0] len;
    } t_burst;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       store_valid;
        logic [5:0] store_index;
        logic [7:0] store_char;
        logic       line_done;
        logic [5:0] line_length;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

[hdl/lne_rx_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lne_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/lne_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface lne_res_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       store_valid;
    logic [5:0] store_index;
    logic [7:0] store_char;
    logic       line_done;
    logic [5:0] line_length;
    logic       last;

    modport source (
        output valid, output echo_valid, output echo_char, output store_valid,
        output store_index, output store_char, output line_done,
        output line_length, output last, input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_char, input store_valid,
        input store_index, input store_char, input line_done,
        input line_length, input last, output ready
    );
endinterface

`default_nettype wire

[hdl/lne_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module lne_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [6:0]    i_cfg_data,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_accept,
    output lne_pkg::t_burst    o_burst,
    output logic               o_has_result
);
    import lne_pkg::*;

    logic [6:0] r_max_length;
    logic       r_echo_enable;
    logic [5:0] r_line_count;
    logic [5:0] n_line_count;

    logic [6:0] w_limit;
    logic [6:0] w_limit_m1;
    logic [5:0] w_inc;
    logic [5:0] w_dec;
    logic       w_done;

    always_comb begin
        if (r_max_length < LIMIT_MIN) begin
            w_limit = LIMIT_MIN;
        end else if (r_max_length > LIMIT_MAX) begin
            w_limit = LIMIT_MAX;
        end else begin
            w_limit = r_max_length;
        end
    end

    assign w_limit_m1 = w_limit - 7'd1;
    assign w_inc      = r_line_count + 6'd1;
    assign w_dec      = r_line_count - 6'd1;
    assign w_done     = ({1'b0, w_inc} >= w_limit_m1);

    always_comb begin
        o_burst       = '0;
        o_burst.kind  = KIND_CHAR;
        o_burst.echo  = r_echo_enable;
        o_burst.ch    = i_byte;
        o_has_result  = 1'b1;
        n_line_count  = r_line_count;
        if (i_byte == CH_CR || i_byte == CH_LF) begin
            o_burst.kind = KIND_EOL;
            o_burst.len  = r_line_count;
            n_line_count = '0;
        end else if (i_byte == CH_BS || i_byte == CH_DEL) begin
            o_burst.kind  = KIND_ERASE;
            o_burst.index = w_dec;
            // erase on an empty line is swallowed
            o_has_result  = (r_line_count != 6'd0);
            if (r_line_count != 6'd0) begin
                n_line_count = w_dec;
            end
        end else begin
            o_burst.index = r_line_count;
            o_burst.done  = w_done;
            o_burst.len   = w_done ? w_inc : 6'd0;
            n_line_count  = w_done ? 6'd0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length  <= MAX_LEN_RST;
            r_echo_enable <= 1'b1;
            r_line_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                    CFG_ECHO_ENABLE: r_echo_enable <= i_cfg_data[0];
                    default:         r_echo_enable <= r_echo_enable;
                endcase
            end
            if (i_accept) begin
                r_line_count <= n_line_count;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/lne_burst.sv]
`timescale 1ns / 1ps
`default_nettype none

module lne_burst (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire lne_pkg::t_burst i_burst,
    output logic               o_free,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output lne_pkg::t_result   o_out
);
    import lne_pkg::*;

    logic       r_pend_valid;
    t_burst     r_pend;
    logic [1:0] r_step;
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_res;
    logic       w_out_load;
    logic       w_adv;

    always_comb begin
        w_res = '0;
        case (r_pend.kind)
            KIND_CHAR: begin
                w_res.echo_valid  = r_pend.echo;
                w_res.echo_char   = r_pend.echo ? r_pend.ch : 8'd0;
                w_res.store_valid = 1'b1;
                w_res.store_index = r_pend.index;
                w_res.store_char  = r_pend.ch;
                w_res.line_done   = r_pend.done;
                w_res.line_length = r_pend.len;
                w_res.last        = 1'b1;
            end
            KIND_EOL: begin
                w_res.echo_valid = 1'b1;
                if (r_step == 2'd0) begin
                    w_res.echo_char = CH_CR;
                end else begin
                    w_res.echo_char   = CH_LF;
                    w_res.line_done   = 1'b1;
                    w_res.line_length = r_pend.len;
                    w_res.last        = 1'b1;
                end
            end
            KIND_ERASE: begin
                w_res.echo_valid = 1'b1;
                if (r_step == 2'd0) begin
                    w_res.echo_char   = CH_BS;
                    w_res.store_valid = 1'b1;
                    w_res.store_index = r_pend.index;
                end else if (r_step == 2'd1) begin
                    w_res.echo_char = CH_SP;
                end else begin
                    w_res.echo_char = CH_BS;
                    w_res.last      = 1'b1;
                end
            end
            default: w_res = '0;
        endcase
    end

    assign w_out_load  = !r_out_valid || i_out_ready;
    assign w_adv       = r_pend_valid && w_out_load;
    assign o_free      = !r_pend_valid || (w_adv && w_res.last);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= r_pend_valid;
            end
            if (i_load) begin
                r_pend_valid <= 1'b1;
                r_step       <= '0;
            end else if (w_adv && w_res.last) begin
                r_pend_valid <= 1'b0;
            end else if (w_adv) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pend <= i_burst;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

[hdl/line_editor_with_echo.sv]
`timescale 1ns / 1ps
`default_nettype none

// Each accepted byte is held in the pending burst register and each result beat
// in the output register. It emits one beat per cycle unless o_res.ready stalls;
// ordinary bytes give one beat, CR/LF two (CR, LF), erase three (BS, SP, BS).
// Erase on an empty line produces nothing and frees the input the same cycle.
// Synchronous active-low reset: line length 0, max_length 64, echo on.
module line_editor_with_echo (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [6:0]  i_cfg_data,
    lne_rx_if.sink           i_rx,
    lne_res_if.source        o_res
);
    import lne_pkg::*;

    t_burst  w_burst;
    logic    w_has_result;
    logic    w_free;
    logic    w_accept;
    logic    w_out_valid;
    t_result w_out;

    assign i_rx.ready = w_free;
    assign w_accept   = i_rx.valid && w_free;

    lne_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_byte       (i_rx.rx_byte),
        .i_accept     (w_accept),
        .o_burst      (w_burst),
        .o_has_result (w_has_result)
    );

    lne_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && w_has_result),
        .i_burst     (w_burst),
        .o_free      (w_free),
        .i_out_ready (o_res.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out)
    );

    assign o_res.valid       = w_out_valid;
    assign o_res.echo_valid  = w_out.echo_valid;
    assign o_res.echo_char   = w_out.echo_char;
    assign o_res.store_valid = w_out.store_valid;
    assign o_res.store_index = w_out.store_index;
    assign o_res.store_char  = w_out.store_char;
    assign o_res.line_done   = w_out.line_done;
    assign o_res.line_length = w_out.line_length;
    assign o_res.last        = w_out.last;

endmodule

`default_nettype wire

[hdl/lne_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lne_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic       i_echo_valid,
    input wire logic [7:0] i_echo_char,
    input wire logic       i_store_valid,
    input wire logic [7:0] i_store_char,
    input wire logic       i_line_done,
    input wire logic       i_last
);
    import lne_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_echo_char) && $stable(i_last))
        else $error("result beat changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_line_done |-> i_last)
        else $error("line_done on a non-final beat");

    // CR of an end-of-line burst is followed at once by its LF beat
    a_eol_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last && i_echo_char == CH_CR && !i_store_valid
        |=> i_valid && i_echo_char == CH_LF && i_last)
        else $error("LF beat missing after CR");

    a_erase_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_store_valid && i_echo_valid && i_echo_char == CH_BS
        && i_store_char == 8'd0 |-> !i_last)
        else $error("erase store on a final beat");

endmodule

bind line_editor_with_echo lne_checker u_lne_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_echo_valid  (o_res.echo_valid),
    .i_echo_char   (o_res.echo_char),
    .i_store_valid (o_res.store_valid),
    .i_store_char  (o_res.store_char),
    .i_line_done   (o_res.line_done),
    .i_last        (o_res.last)
);

`default_nettype wire
